### rtl/hws_pkg.sv
// Shared types, constants and coefficient table for the Hamming window smoother.
package hws_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_HALF_DEF  = 7;
    localparam int COEF_BITS_DEF = 16;
    localparam int ROM_HALVES    = 7;
    localparam int ROM_BITS      = 24;
    localparam int HALF_W        = 3;
    localparam int TAP_W         = 3;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(2);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_missing;
        logic                          last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smoothed;
        logic                          result_missing;
        logic                          result_last;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr;         // store the accepted sample
        logic             clr;        // clear accumulator and missing flag
        logic             rd;         // issue a store read
        logic             mac;        // read feeds the multiply-accumulate
        logic             ctr;        // read is the window center
        logic [TAP_W-1:0] tap_m;      // coefficient column for the read
        logic             load_mac;   // load filtered result into output
        logic             load_pass;  // load read entry as passthrough
        logic             last_flag;  // mark loaded result as final
        logic             restart;    // begin a new series
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [HALF_W-1:0] half;
        logic              last;
        logic              pipe_busy;
        logic              out_free;
    } t_dp_status;

    // Normalized Hamming weights, unsigned Q0.24; row h-1, column m is the
    // distance of the tap from the nearer window edge.
    localparam logic [ROM_BITS-1:0] COEF_ROM [ROM_HALVES][ROM_HALVES+1] = '{
        '{24'd1157049, 24'd14463117, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0},
        '{24'd599186, 24'd4044507, 24'd7489829, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0},
        '{24'd404270, 24'd1566547, 24'd3891101, 24'd5053378,
          24'd0, 24'd0, 24'd0, 24'd0},
        '{24'd305040, 24'd818770, 24'd2059022, 24'd3299274,
          24'd3813004, 24'd0, 24'd0, 24'd0},
        '{24'd244923, 24'd513885, 24'd1218039, 24'd2088420,
          24'd2792573, 24'd3061536, 24'd0, 24'd0},
        '{24'd204600, 24'd362215, 24'd792826, 24'd1381051,
          24'd1969277, 24'd2399888, 24'd2557502, 24'd0},
        '{24'd175678, 24'd275714, 24'd556008, 24'd961045,
          24'd1410603, 24'd1815640, 24'd2095935, 24'd2195971}
    };

endpackage

### rtl/hamming_window_smoother_core.sv
// Top level of the Hamming window smoother: controller plus datapath.
//
//  channel  handshake                   payload
//  in       i_in_valid / o_in_stall     i_in_data  (t_in_item)
//  out      o_out_valid / i_out_stall   o_out_data (t_out_item)
//  cfg      i_cfg_wr_en                 i_cfg_wr_data (half width)
//
// A transfer into the store is followed by a decide step; a filtered result
// then walks the shared multiply-accumulate over 2h+1 taps and waits for the
// read and product registers to drain. A passthrough result takes one store
// read; each flushed tail entry adds a read and an emit. Reset is synchronous
// and clears the sequencer, pointer, sample count and sets the half width to
// 2; the sample store is not cleared. A stalled output holds the sequencer.
module hamming_window_smoother_core import hws_pkg::*; #(
    parameter int MAX_HALF  = MAX_HALF_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [HALF_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    localparam int DEPTH  = 2 * MAX_HALF + 1;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int SEEN_W = $clog2(DEPTH + 1);

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [PTR_W-1:0]  rd_back;
    logic [SEEN_W-1:0] seen;

    hws_ctrl #(
        .MAX_HALF (MAX_HALF)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .i_seen     (seen),
        .o_cmd      (cmd),
        .o_rd_back  (rd_back)
    );

    hws_dp #(
        .MAX_HALF  (MAX_HALF),
        .COEF_BITS (COEF_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_cmd         (cmd),
        .i_rd_back     (rd_back),
        .o_status      (status),
        .o_seen        (seen),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );

endmodule

### rtl/hws_dp.sv
// Datapath: sample store, read pipeline, shared multiply-accumulate, output register.
module hws_dp import hws_pkg::*; #(
    parameter int MAX_HALF  = MAX_HALF_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF,
    localparam int DEPTH    = 2 * MAX_HALF + 1,
    localparam int PTR_W    = $clog2(DEPTH),
    localparam int SEEN_W   = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [HALF_W-1:0] i_cfg_wr_data,
    input  t_in_item          i_in_data,
    input  t_dp_cmd           i_cmd,
    input  logic [PTR_W-1:0]  i_rd_back,
    output t_dp_status        o_status,
    output logic [SEEN_W-1:0] o_seen,
    output logic              o_out_valid,
    output t_out_item         o_out_data,
    input  logic              i_out_stall
);

    localparam int PROD_W = COEF_BITS + 1 + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 4;
    localparam int Q_W    = ACC_W - COEF_BITS;
    localparam int RSH    = ROM_BITS - COEF_BITS;
    localparam logic [ROM_BITS:0] RND =
        (ROM_BITS + 1)'((RSH > 0) ? (64'd1 << ((RSH > 0) ? RSH - 1 : 0)) : 64'd0);
    localparam logic [HALF_W-1:0] HALF_LIM =
        HALF_W'((MAX_HALF < ROM_HALVES) ? MAX_HALF : ROM_HALVES);
    localparam logic signed [Q_W-1:0] MAXV =
        Q_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [Q_W-1:0] MINV = ~MAXV;
    localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(64'd1 << (COEF_BITS - 1));

    logic [HALF_W-1:0]       r_half_width;
    logic [SAMPLE_BITS:0]    r_store [DEPTH];
    logic [PTR_W-1:0]        r_wp, n_wp;
    logic [SEEN_W-1:0]       r_seen, n_seen;
    logic [SEEN_W-1:0]       r_i;
    logic [HALF_W-1:0]       r_h, n_h;
    logic                    r_last;
    logic [SAMPLE_BITS:0]    r_rd_data;
    logic                    r_v1;
    logic [TAP_W-1:0]        r_m1;
    logic                    r_ctr1;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_v2;
    logic                    r_any;
    logic [SAMPLE_BITS:0]    r_center;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic [PTR_W:0]          rd_sum;
    logic [PTR_W-1:0]        rd_addr;
    logic [ROM_BITS-1:0]     rom_val;
    logic [ROM_BITS:0]       coef_sum;
    logic [COEF_BITS-1:0]    coef;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0] rnd_t;
    logic signed [Q_W-1:0]   q;
    logic signed [SAMPLE_BITS-1:0] sat;
    logic                    out_free;
    t_out_item               n_out;

    // Effective half width: clamp to 1..HALF_LIM
    always_comb begin
        if (r_half_width == '0) begin
            n_h = HALF_W'(1);
        end else if (r_half_width > HALF_LIM) begin
            n_h = HALF_LIM;
        end else begin
            n_h = r_half_width;
        end
    end

    assign n_wp   = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
    assign n_seen = (r_seen < SEEN_W'(DEPTH)) ? r_seen + SEEN_W'(1) : r_seen;

    // Entry written i_rd_back transfers ago, counted from the newest
    always_comb begin
        rd_sum = {1'b0, r_wp} + (PTR_W + 1)'(DEPTH - 1) - {1'b0, i_rd_back};
        if (rd_sum >= (PTR_W + 1)'(DEPTH)) begin
            rd_sum = rd_sum - (PTR_W + 1)'(DEPTH);
        end
        rd_addr = rd_sum[PTR_W-1:0];
    end

    // Round the Q0.24 weight half-up to Q0.COEF_BITS
    assign rom_val  = COEF_ROM[r_h - HALF_W'(1)][r_m1];
    assign coef_sum = {1'b0, rom_val} + RND;
    assign coef     = COEF_BITS'(coef_sum >> RSH);
    assign prod     = $signed({1'b0, coef}) * $signed(r_rd_data[SAMPLE_BITS-1:0]);

    // Round to nearest, ties up, then saturate
    assign rnd_t = r_acc + $signed(HALF_LSB);
    assign q     = Q_W'(rnd_t >>> COEF_BITS);
    always_comb begin
        if (q > MAXV) begin
            sat = SAMPLE_BITS'(MAXV);
        end else if (q < MINV) begin
            sat = SAMPLE_BITS'(MINV);
        end else begin
            sat = SAMPLE_BITS'(q);
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out = r_out_data;
        if (i_cmd.load_mac) begin
            if (r_center[SAMPLE_BITS]) begin
                n_out.smoothed       = r_center[SAMPLE_BITS-1:0];
                n_out.result_missing = 1'b1;
            end else if (r_any) begin
                n_out.smoothed       = '0;
                n_out.result_missing = 1'b1;
            end else begin
                n_out.smoothed       = sat;
                n_out.result_missing = 1'b0;
            end
            n_out.result_last = 1'b0;
        end else if (i_cmd.load_pass) begin
            n_out.smoothed       = r_rd_data[SAMPLE_BITS-1:0];
            n_out.result_missing = r_rd_data[SAMPLE_BITS];
            n_out.result_last    = i_cmd.last_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= HALF_RESET;
            r_wp         <= '0;
            r_seen       <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_half_width <= i_cfg_wr_data;
            end
            if (i_cmd.restart) begin
                r_wp   <= '0;
                r_seen <= '0;
            end else if (i_cmd.wr) begin
                r_wp   <= n_wp;
                r_seen <= n_seen;
            end
            r_v1 <= i_cmd.rd && i_cmd.mac;
            r_v2 <= r_v1;
            if (i_cmd.load_mac || i_cmd.load_pass) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_store[r_wp] <= {i_in_data.sample_missing, i_in_data.sample};
            r_i           <= r_seen;
            r_h           <= n_h;
            r_last        <= i_in_data.last_sample;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_store[rd_addr];
            r_m1      <= i_cmd.tap_m;
            r_ctr1    <= i_cmd.ctr;
        end
        if (r_v1) begin
            r_prod <= prod;
        end
        if (i_cmd.clr) begin
            r_any <= 1'b0;
        end else if (r_v1) begin
            r_any <= r_any | r_rd_data[SAMPLE_BITS];
            if (r_ctr1) begin
                r_center <= r_rd_data;
            end
        end
        if (i_cmd.clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.load_mac || i_cmd.load_pass) begin
            r_out_data <= n_out;
        end
    end

    assign o_status.half      = r_h;
    assign o_status.last      = r_last;
    assign o_status.pipe_busy = r_v1 || r_v2;
    assign o_status.out_free  = out_free;
    assign o_seen             = r_i;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;

endmodule

### rtl/hws_ctrl.sv
// Controller: sequences store writes, tap walk, passthrough reads and tail flush.
module hws_ctrl import hws_pkg::*; #(
    parameter int MAX_HALF = MAX_HALF_DEF,
    localparam int DEPTH   = 2 * MAX_HALF + 1,
    localparam int PTR_W   = $clog2(DEPTH),
    localparam int SEEN_W  = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_dp_status        i_status,
    input  logic [SEEN_W-1:0] i_seen,
    output t_dp_cmd           o_cmd,
    output logic [PTR_W-1:0]  o_rd_back
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECIDE    = 9'b000000010,
        S_WALK      = 9'b000000100,
        S_MAC_EMIT  = 9'b000001000,
        S_PASS_RD   = 9'b000010000,
        S_PASS_EMIT = 9'b000100000,
        S_FL_RD     = 9'b001000000,
        S_FL_EMIT   = 9'b010000000,
        S_SPARE     = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_cnt, n_cnt;

    logic [PTR_W-1:0]  h_p, h2_p;
    logic [SEEN_W-1:0] h_s, h2_s, hm1_s;
    logic [PTR_W-1:0]  fl_init;

    assign h_p   = PTR_W'(i_status.half);
    assign h2_p  = h_p << 1;
    assign h_s   = SEEN_W'(i_status.half);
    assign h2_s  = h_s << 1;
    assign hm1_s = SEEN_W'(i_status.half - HALF_W'(1));
    assign fl_init = (i_seen < hm1_s) ? PTR_W'(i_seen) : PTR_W'(hm1_s);

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd     = '0;
        o_rd_back = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.clr = 1'b1;
                n_cnt     = '0;
                if (i_seen >= h2_s) begin
                    n_state = S_WALK;
                end else if (i_seen >= h_s) begin
                    n_state = S_PASS_RD;
                end else if (i_status.last) begin
                    n_cnt   = fl_init;
                    n_state = S_FL_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                // tap k reads the entry 2h-k transfers back
                o_cmd.rd    = 1'b1;
                o_cmd.mac   = 1'b1;
                o_cmd.ctr   = (r_cnt == h_p);
                o_cmd.tap_m = (r_cnt <= h_p) ? TAP_W'(r_cnt) : TAP_W'(h2_p - r_cnt);
                o_rd_back   = h2_p - r_cnt;
                if (r_cnt == h2_p) begin
                    n_state = S_MAC_EMIT;
                end else begin
                    n_cnt = r_cnt + PTR_W'(1);
                end
            end
            S_MAC_EMIT: begin
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.load_mac = 1'b1;
                    if (i_status.last) begin
                        n_cnt   = fl_init;
                        n_state = S_FL_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PASS_RD: begin
                o_cmd.rd  = 1'b1;
                o_rd_back = h_p;
                n_state   = S_PASS_EMIT;
            end
            S_PASS_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_pass = 1'b1;
                    if (i_status.last) begin
                        n_cnt   = fl_init;
                        n_state = S_FL_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FL_RD: begin
                o_cmd.rd  = 1'b1;
                o_rd_back = r_cnt;
                n_state   = S_FL_EMIT;
            end
            S_FL_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_pass = 1'b1;
                    o_cmd.last_flag = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt - PTR_W'(1);
                        n_state = S_FL_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
